### src/lcc_pkg.sv
// Shared types, codes and constants of the line crossing counter.
`timescale 1ns / 1ps
package lcc_pkg;

   localparam int TRACK_ID_W     = 6;
   localparam int CENTROID_W     = 16;
   localparam int COORD_W        = 12;
   localparam int COUNT_W        = 16;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 12;
   localparam int LCC_MAX_TRACKS = 64;
   localparam int QUEUE_DEPTH    = 2;

   typedef logic [1:0] side_type;
   localparam side_type SIDE_NONE = 2'd0;
   localparam side_type SIDE_A    = 2'd1;
   localparam side_type SIDE_B    = 2'd2;

   typedef logic [1:0] snap_mode_type;
   localparam snap_mode_type SNAP_ANY      = 2'd0;
   localparam snap_mode_type SNAP_ARRIVE_B = 2'd1;
   localparam snap_mode_type SNAP_ARRIVE_A = 2'd2;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_START_X = 3'd0;
   localparam csr_index_type CSR_START_Y = 3'd1;
   localparam csr_index_type CSR_END_X   = 3'd2;
   localparam csr_index_type CSR_END_Y   = 3'd3;
   localparam csr_index_type CSR_ENABLE  = 3'd4;
   localparam csr_index_type CSR_MODE    = 3'd5;

   typedef struct packed {
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
      logic               enable;
   } line_cfg_type;

   typedef struct packed {
      logic [TRACK_ID_W-1:0] track_id;
      side_type              side;
      logic                  inactive;
   } item_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_UPDATE
   } back_state_type;

endpackage

### src/lcc_front.sv
// Front stage: takes track updates and classifies the centroid against the line.
`timescale 1ns / 1ps
module lcc_front import lcc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  line_cfg_type          line_cfg,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [TRACK_ID_W-1:0] req_track_id,
   input  logic [CENTROID_W-1:0] req_centroid_x,
   input  logic [CENTROID_W-1:0] req_centroid_y,
   input  logic                  req_track_inactive,
   output logic                  push_valid,
   output item_type              push_item,
   input  logic                  queue_full
);

   logic                stage_valid_ff;
   logic                stage_valid_in;
   item_type            stage_item_ff;
   logic                take;
   logic [COORD_W-1:0]  span_x;
   logic [COORD_W-1:0]  span_y;
   logic [CENTROID_W-1:0] line_x;
   logic [CENTROID_W-1:0] line_y;
   side_type            side;

   assign req_stall = stage_valid_ff && queue_full;
   assign take      = req_valid && !req_stall;

   always_comb begin
      span_x = (line_cfg.start_x > line_cfg.end_x) ? line_cfg.start_x - line_cfg.end_x
                                                   : line_cfg.end_x - line_cfg.start_x;
      span_y = (line_cfg.start_y > line_cfg.end_y) ? line_cfg.start_y - line_cfg.end_y
                                                   : line_cfg.end_y - line_cfg.start_y;
      line_x = {line_cfg.start_x, 4'b0000};
      line_y = {line_cfg.start_y, 4'b0000};
      side   = SIDE_NONE;
      if (line_cfg.enable) begin
         if (span_x < span_y) begin
            if (req_centroid_x < line_x) begin
               side = SIDE_A;
            end else if (req_centroid_x > line_x) begin
               side = SIDE_B;
            end
         end else if (span_x > span_y) begin
            if (req_centroid_y > line_y) begin
               side = SIDE_A;
            end else if (req_centroid_y < line_y) begin
               side = SIDE_B;
            end
         end
      end
   end

   assign stage_valid_in = take || (stage_valid_ff && queue_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         stage_item_ff.track_id <= req_track_id;
         stage_item_ff.side     <= side;
         stage_item_ff.inactive <= req_track_inactive;
      end
   end

   assign push_valid = stage_valid_ff;
   assign push_item  = stage_item_ff;

endmodule

### src/lcc_queue.sv
// Short queue of classified items between front and back.
`timescale 1ns / 1ps
module lcc_queue import lcc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  item_type push_item,
   output logic     full,
   output logic     pop_valid,
   output item_type pop_item,
   input  logic     pop
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
   localparam logic [CntW-1:0] DepthCnt = CntW'(QUEUE_DEPTH);

   item_type        entry_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [PtrW-1:0] rd_ptr_in;
   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;
   logic            do_push;
   logic            do_pop;

   assign full      = (count_ff == DepthCnt);
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DepthCnt)
      else $error("queue count beyond depth");

endmodule

### src/lcc_back.sv
// Back stage: side table read-modify-write, crossing counters and result register.
`timescale 1ns / 1ps
module lcc_back import lcc_pkg::*; #(
   parameter int MAX_TRACKS = LCC_MAX_TRACKS
) (
   input  logic               clock,
   input  logic               reset,
   input  snap_mode_type      snapshot_mode,
   input  logic               item_valid,
   input  item_type           item,
   output logic               item_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_side_now,
   output logic               rsp_snapshot,
   output logic [COUNT_W-1:0] rsp_count_a_to_b,
   output logic [COUNT_W-1:0] rsp_count_b_to_a
);

   localparam int TableDepth = (MAX_TRACKS < (1 << TRACK_ID_W)) ? MAX_TRACKS
                                                                : (1 << TRACK_ID_W);
   localparam int IdxW = $clog2(TableDepth);
   localparam logic [TRACK_ID_W:0] TableLimit = (TRACK_ID_W + 1)'(TableDepth);
   localparam logic [COUNT_W-1:0]  CountMax   = '1;

   back_state_type     state_ff;
   back_state_type     state_in;
   side_type           side_mem [TableDepth];
   logic [TableDepth-1:0] side_vld_ff;
   item_type           cur_ff;
   side_type           old_side_ff;
   logic [IdxW-1:0]    rd_idx;
   logic [IdxW-1:0]    cur_idx;
   logic               in_table;
   logic               fire;
   logic               slot_free;
   logic               tbl_we;
   side_type           tbl_wdata;
   logic               inc_ab;
   logic               inc_ba;
   logic               snap;
   logic [COUNT_W-1:0] count_ab_ff;
   logic [COUNT_W-1:0] count_ab_in;
   logic [COUNT_W-1:0] count_ba_ff;
   logic [COUNT_W-1:0] count_ba_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   side_type           rsp_side_ff;
   logic               rsp_snap_ff;

   assign rd_idx    = item.track_id[IdxW-1:0];
   assign cur_idx   = cur_ff.track_id[IdxW-1:0];
   assign in_table  = ({1'b0, cur_ff.track_id} < TableLimit);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      item_pop = 1'b0;
      fire     = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               state_in = BK_UPDATE;
            end
         end
         BK_UPDATE: begin
            if (slot_free) begin
               fire     = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      tbl_we    = 1'b0;
      tbl_wdata = SIDE_NONE;
      inc_ab    = 1'b0;
      inc_ba    = 1'b0;
      snap      = 1'b0;
      if (in_table) begin
         if (cur_ff.inactive) begin
            tbl_we = 1'b1;
         end else if (old_side_ff != SIDE_NONE) begin
            if (cur_ff.side != old_side_ff) begin
               tbl_we = 1'b1;
               inc_ab = (old_side_ff == SIDE_A) && (cur_ff.side == SIDE_B);
               inc_ba = (old_side_ff == SIDE_B) && (cur_ff.side == SIDE_A);
               case (snapshot_mode)
                  SNAP_ANY:      snap = (cur_ff.side != SIDE_NONE);
                  SNAP_ARRIVE_B: snap = (cur_ff.side == SIDE_B);
                  SNAP_ARRIVE_A: snap = (cur_ff.side == SIDE_A);
                  default:       snap = 1'b0;
               endcase
            end
         end else begin
            tbl_we    = 1'b1;
            tbl_wdata = cur_ff.side;
         end
      end
      count_ab_in = (inc_ab && count_ab_ff != CountMax) ? count_ab_ff + 1'b1 : count_ab_ff;
      count_ba_in = (inc_ba && count_ba_ff != CountMax) ? count_ba_ff + 1'b1 : count_ba_ff;
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         cur_ff      <= item;
         old_side_ff <= side_vld_ff[rd_idx] ? side_mem[rd_idx] : SIDE_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && tbl_we) begin
         side_mem[cur_idx] <= tbl_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_vld_ff <= '0;
      end else if (fire && tbl_we) begin
         side_vld_ff[cur_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ab_ff <= '0;
         count_ba_ff <= '0;
      end else if (fire) begin
         count_ab_ff <= count_ab_in;
         count_ba_ff <= count_ba_in;
      end
   end

   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_side_ff <= cur_ff.side;
         rsp_snap_ff <= snap;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_side_now     = rsp_side_ff;
   assign rsp_snapshot     = rsp_snap_ff;
   assign rsp_count_a_to_b = count_ab_ff;
   assign rsp_count_b_to_a = count_ba_ff;

   a_snap_needs_side: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_snap_ff |-> rsp_side_ff != SIDE_NONE)
      else $error("snapshot without a side");

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ab_ff >= $past(count_ab_ff))
                     && (count_ba_ff >= $past(count_ba_ff)))
      else $error("crossing counter went down");

   a_count_on_update: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (count_ab_ff != $past(count_ab_ff) || count_ba_ff != $past(count_ba_ff))
      |-> $past(state_ff == BK_UPDATE) && rsp_valid_ff)
      else $error("counter changed outside an update");

endmodule

### src/line_crossing_counter_top.sv
// Top level of the line crossing counter: config registers, front, queue and back.
//
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  track_id, centroid_x, centroid_y, track_inactive
// rsp      out        rsp_valid/rsp_stall  side_now, snapshot, count_a_to_b, count_b_to_a
// csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// The back stage reads the side table as it pops an item; the table write, counter update
// and result load wait for a free result register before the next item is popped.
// A request is registered in the front stage, the queue, the back stage and the result.
// Reset clears counters, all side table entries (per-entry valid bits) and the queue.
// rsp_stall holds the result; the front stage and queue keep taking items until full.
`timescale 1ns / 1ps
module line_crossing_counter_top import lcc_pkg::*; #(
   parameter int MAX_TRACKS = LCC_MAX_TRACKS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [TRACK_ID_W-1:0]  req_track_id,
   input  logic [CENTROID_W-1:0]  req_centroid_x,
   input  logic [CENTROID_W-1:0]  req_centroid_y,
   input  logic                   req_track_inactive,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_side_now,
   output logic                   rsp_snapshot,
   output logic [COUNT_W-1:0]     rsp_count_a_to_b,
   output logic [COUNT_W-1:0]     rsp_count_b_to_a,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   line_cfg_type  line_cfg_ff;
   snap_mode_type snap_mode_ff;
   logic          push_valid;
   item_type      push_item;
   logic          queue_full;
   logic          pop_valid;
   item_type      pop_item;
   logic          pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_cfg_ff  <= '0;
         snap_mode_ff <= SNAP_ARRIVE_B;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_START_X: line_cfg_ff.start_x <= csr_wdata;
            CSR_START_Y: line_cfg_ff.start_y <= csr_wdata;
            CSR_END_X:   line_cfg_ff.end_x   <= csr_wdata;
            CSR_END_Y:   line_cfg_ff.end_y   <= csr_wdata;
            CSR_ENABLE:  line_cfg_ff.enable  <= csr_wdata[0];
            CSR_MODE:    snap_mode_ff        <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   lcc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .line_cfg           (line_cfg_ff),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_track_id       (req_track_id),
      .req_centroid_x     (req_centroid_x),
      .req_centroid_y     (req_centroid_y),
      .req_track_inactive (req_track_inactive),
      .push_valid         (push_valid),
      .push_item          (push_item),
      .queue_full         (queue_full)
   );

   lcc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop        (pop)
   );

   lcc_back #(
      .MAX_TRACKS (MAX_TRACKS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .snapshot_mode    (snap_mode_ff),
      .item_valid       (pop_valid),
      .item             (pop_item),
      .item_pop         (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_side_now     (rsp_side_now),
      .rsp_snapshot     (rsp_snapshot),
      .rsp_count_a_to_b (rsp_count_a_to_b),
      .rsp_count_b_to_a (rsp_count_b_to_a)
   );

endmodule

### test/tb.sv
// Self-checking testbench for the line crossing counter: random and directed track updates.
`timescale 1ns / 1ps
module tb;
   import lcc_pkg::*;

   localparam int            CYCLE_LIMIT  = 3000000;
   localparam snap_mode_type SNAP_UNUSED  = 2'd3;
   localparam int            DRAIN_CYCLES = 8;

   typedef enum logic [1:0] {
      LINE_OFF,
      LINE_STEEP,
      LINE_FLAT
   } slope_type;

   typedef struct {
      logic [TRACK_ID_W-1:0] track_id;
      logic [CENTROID_W-1:0] centroid_x;
      logic [CENTROID_W-1:0] centroid_y;
      logic                  inactive;
   } update_type;

   typedef struct {
      side_type           side;
      logic               snapshot;
      logic [COUNT_W-1:0] a_to_b;
      logic [COUNT_W-1:0] b_to_a;
   } crossing_result_type;

   logic                   clock              = 1'b0;
   logic                   reset              = 1'b1;
   logic                   req_valid          = 1'b0;
   logic                   req_stall;
   logic [TRACK_ID_W-1:0]  req_track_id       = '0;
   logic [CENTROID_W-1:0]  req_centroid_x     = '0;
   logic [CENTROID_W-1:0]  req_centroid_y     = '0;
   logic                   req_track_inactive = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall          = 1'b0;
   logic [1:0]             rsp_side_now;
   logic                   rsp_snapshot;
   logic [COUNT_W-1:0]     rsp_count_a_to_b;
   logic [COUNT_W-1:0]     rsp_count_b_to_a;
   logic                   csr_valid          = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index          = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata          = '0;

   // crossing predictor state
   line_cfg_type        line_cfg      = '0;
   snap_mode_type       snap_mode     = SNAP_ARRIVE_B;
   side_type            side_memory[LCC_MAX_TRACKS];
   logic [COUNT_W-1:0]  a_to_b_total  = '0;
   logic [COUNT_W-1:0]  b_to_a_total  = '0;

   update_type          pending_updates[$];
   crossing_result_type expected_results[$];

   bit          idle_on         = 1'b1;
   int unsigned hold_ask        = 0;
   int unsigned mismatch_count  = 0;
   int unsigned updates_sent    = 0;
   int unsigned results_checked = 0;
   int unsigned snaps_seen      = 0;
   int unsigned settings_run    = 0;
   int unsigned cycle_count     = 0;

   line_crossing_counter_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_track_id       (req_track_id),
      .req_centroid_x     (req_centroid_x),
      .req_centroid_y     (req_centroid_y),
      .req_track_inactive (req_track_inactive),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_side_now       (rsp_side_now),
      .rsp_snapshot       (rsp_snapshot),
      .rsp_count_a_to_b   (rsp_count_a_to_b),
      .rsp_count_b_to_a   (rsp_count_b_to_a),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      foreach (side_memory[i]) side_memory[i] = SIDE_NONE;
   end

   function automatic slope_type slope_of_line();
      logic [COORD_W-1:0] dx;
      logic [COORD_W-1:0] dy;
      dx = (line_cfg.start_x > line_cfg.end_x) ? line_cfg.start_x - line_cfg.end_x
                                               : line_cfg.end_x - line_cfg.start_x;
      dy = (line_cfg.start_y > line_cfg.end_y) ? line_cfg.start_y - line_cfg.end_y
                                               : line_cfg.end_y - line_cfg.start_y;
      if (!line_cfg.enable || dx == dy) return LINE_OFF;
      return (dx < dy) ? LINE_STEEP : LINE_FLAT;
   endfunction

   function automatic side_type side_for(logic [CENTROID_W-1:0] cx, logic [CENTROID_W-1:0] cy);
      logic [CENTROID_W-1:0] lx;
      logic [CENTROID_W-1:0] ly;
      lx = {line_cfg.start_x, 4'h0};
      ly = {line_cfg.start_y, 4'h0};
      case (slope_of_line())
         LINE_STEEP: return (cx < lx) ? SIDE_A : (cx > lx) ? SIDE_B : SIDE_NONE;
         LINE_FLAT:  return (cy > ly) ? SIDE_A : (cy < ly) ? SIDE_B : SIDE_NONE;
         default:    return SIDE_NONE;
      endcase
   endfunction

   task automatic predict_crossing(input update_type u);
      crossing_result_type r;
      side_type            side_here;
      side_type            prior;
      side_here  = side_for(u.centroid_x, u.centroid_y);
      prior      = side_memory[u.track_id];
      r.snapshot = 1'b0;
      if (u.inactive) begin
         side_memory[u.track_id] = SIDE_NONE;
      end else if (prior != SIDE_NONE) begin
         if (side_here != prior) begin
            if (prior == SIDE_A && side_here == SIDE_B && a_to_b_total != '1)
               a_to_b_total = a_to_b_total + 1'b1;
            if (prior == SIDE_B && side_here == SIDE_A && b_to_a_total != '1)
               b_to_a_total = b_to_a_total + 1'b1;
            case (snap_mode)
               SNAP_ANY:      r.snapshot = (side_here != SIDE_NONE);
               SNAP_ARRIVE_B: r.snapshot = (side_here == SIDE_B);
               SNAP_ARRIVE_A: r.snapshot = (side_here == SIDE_A);
               default:       r.snapshot = 1'b0;
            endcase
            side_memory[u.track_id] = SIDE_NONE;
         end
      end else begin
         side_memory[u.track_id] = side_here;
      end
      r.side   = side_here;
      r.a_to_b = a_to_b_total;
      r.b_to_a = b_to_a_total;
      expected_results.insert(expected_results.size(), r);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("mismatch in %s at result %0d: got %0h, expected %0h",
                  what, results_checked, got, want);
   endtask

   function automatic int idle_length();
      return ($urandom_range(9, 0) < 8) ? $urandom_range(3, 1) : $urandom_range(24, 6);
   endfunction

   // driver
   always @(posedge clock) begin : driver
      int         send_gap;
      update_type u;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_crossing('{req_track_id, req_centroid_x, req_centroid_y,
                               req_track_inactive});
            updates_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_updates.size() > 0) begin
               u = pending_updates.pop_front();
               req_track_id       <= u.track_id;
               req_centroid_x     <= u.centroid_x;
               req_centroid_y     <= u.centroid_y;
               req_track_inactive <= u.inactive;
               req_valid          <= 1'b1;
               send_gap = (idle_on && $urandom_range(99, 0) < 30) ? idle_length() : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result stall, including long hold-offs on request
   always @(posedge clock) begin : stall_gen
      int          stall_left;
      int unsigned hold_seen;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         hold_seen  = hold_ask;
      end else if (hold_ask != hold_seen) begin
         hold_seen  = hold_ask;
         stall_left = 79;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(99, 0) < 20) begin
         stall_left = idle_length() - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      crossing_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch("transfer with nothing expected", 32'(rsp_side_now), 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_side_now !== want.side)
               report_mismatch("side_now", 32'(rsp_side_now), 32'(want.side));
            if (rsp_snapshot !== want.snapshot)
               report_mismatch("snapshot", 32'(rsp_snapshot), 32'(want.snapshot));
            if (rsp_count_a_to_b !== want.a_to_b)
               report_mismatch("count_a_to_b", 32'(rsp_count_a_to_b), 32'(want.a_to_b));
            if (rsp_count_b_to_a !== want.b_to_a)
               report_mismatch("count_b_to_a", 32'(rsp_count_b_to_a), 32'(want.b_to_a));
         end
         results_checked++;
         if (rsp_snapshot === 1'b1) snaps_seen++;
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("FAIL");
         $finish;
      end
   end

   task automatic drain();
      while (pending_updates.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_START_X: line_cfg.start_x = val;
         CSR_START_Y: line_cfg.start_y = val;
         CSR_END_X:   line_cfg.end_x   = val;
         CSR_END_Y:   line_cfg.end_y   = val;
         CSR_ENABLE:  line_cfg.enable  = val[0];
         CSR_MODE:    snap_mode        = val[1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic set_line(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                           input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey,
                           input logic en, input snap_mode_type mode);
      drain();
      write_csr(CSR_START_X, sx);
      write_csr(CSR_START_Y, sy);
      write_csr(CSR_END_X, ex);
      write_csr(CSR_END_Y, ey);
      write_csr(CSR_ENABLE, {{(CSR_DATA_W-1){1'b0}}, en});
      write_csr(CSR_MODE, {{(CSR_DATA_W-2){1'b0}}, mode});
      settings_run++;
   endtask

   task automatic add_update(input update_type u);
      pending_updates.insert(pending_updates.size(), u);
   endtask

   task automatic queue_update(input logic [TRACK_ID_W-1:0] id,
                               input logic [CENTROID_W-1:0] cx,
                               input logic [CENTROID_W-1:0] cy, input logic inactive);
      add_update('{id, cx, cy, inactive});
   endtask

   // place a centroid on the requested side of the current line, often right next to it
   function automatic update_type make_crossing(logic [TRACK_ID_W-1:0] id, side_type want);
      update_type            u;
      logic [CENTROID_W-1:0] lx;
      logic [CENTROID_W-1:0] ly;
      bit                    near;
      lx         = {line_cfg.start_x, 4'h0};
      ly         = {line_cfg.start_y, 4'h0};
      near       = ($urandom_range(2, 0) == 0);
      u.track_id   = id;
      u.centroid_x = CENTROID_W'($urandom);
      u.centroid_y = CENTROID_W'($urandom);
      u.inactive   = 1'b0;
      case (slope_of_line())
         LINE_STEEP: begin
            if (want == SIDE_A && lx != 0)
               u.centroid_x = near ? lx - 16'd1
                                   : CENTROID_W'($urandom_range(lx - 16'd1, 0));
            else if (want == SIDE_B && lx != '1)
               u.centroid_x = near ? lx + 16'd1
                                   : CENTROID_W'($urandom_range(16'hFFFF, lx + 16'd1));
            else if (want == SIDE_NONE)
               u.centroid_x = lx;
         end
         LINE_FLAT: begin
            if (want == SIDE_A && ly != '1)
               u.centroid_y = near ? ly + 16'd1
                                   : CENTROID_W'($urandom_range(16'hFFFF, ly + 16'd1));
            else if (want == SIDE_B && ly != 0)
               u.centroid_y = near ? ly - 16'd1
                                   : CENTROID_W'($urandom_range(ly - 16'd1, 0));
            else if (want == SIDE_NONE)
               u.centroid_y = ly;
         end
         default: ;
      endcase
      return u;
   endfunction

   function automatic update_type random_update(int id_span);
      update_type u;
      int         r;
      side_type   want;
      r = $urandom_range(99, 0);
      if (r < 75) begin
         r    = $urandom_range(99, 0);
         want = (r < 45) ? SIDE_A : (r < 90) ? SIDE_B : SIDE_NONE;
         u    = make_crossing(TRACK_ID_W'($urandom_range(id_span - 1, 0)), want);
         u.inactive = ($urandom_range(19, 0) == 0);
      end else begin
         u.track_id   = TRACK_ID_W'($urandom);
         u.centroid_x = CENTROID_W'($urandom);
         u.centroid_y = CENTROID_W'($urandom);
         u.inactive   = 1'($urandom);
      end
      return u;
   endfunction

   task automatic run_phase(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                            input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey,
                            input logic en, input snap_mode_type mode, input int count,
                            input int id_span, input bit with_hold);
      set_line(sx, sy, ex, ey, en, mode);
      for (int n = 0; n < count; n++) begin
         if (n % 25 == 0) begin
            while (pending_updates.size() > 4) @(posedge clock);
            idle_on = ($urandom_range(3, 0) != 0);
            if (with_hold && n == 25) hold_ask++;
         end
         add_update(random_update(id_span));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // steep line through x = 100 px, so the boundary sits at 1600
      set_line(12'd100, 12'd50, 12'd110, 12'd900, 1'b1, SNAP_ANY);
      queue_update(6'd0, 16'd1599, 16'd7, 1'b0);
      queue_update(6'd0, 16'd1000, 16'd9999, 1'b0);
      queue_update(6'd0, 16'd1601, 16'd0, 1'b0);
      queue_update(6'd0, 16'd1601, 16'd0, 1'b0);
      queue_update(6'd0, 16'd0, 16'hFFFF, 1'b0);
      queue_update(6'd1, 16'd1599, 16'd0, 1'b0);
      queue_update(6'd1, 16'd1600, 16'd123, 1'b0);
      queue_update(6'd1, 16'd1600, 16'd5, 1'b0);
      queue_update(6'd1, 16'hFFFF, 16'd0, 1'b0);
      queue_update(6'd2, 16'd100, 16'd0, 1'b0);
      queue_update(6'd2, 16'd100, 16'd0, 1'b1);
      queue_update(6'd2, 16'd2000, 16'd0, 1'b0);
      queue_update(6'd2, 16'd2000, 16'd0, 1'b1);
      queue_update(6'd63, 16'd0, 16'd0, 1'b0);
      queue_update(6'd63, 16'hFFFF, 16'hFFFF, 1'b0);
      queue_update(6'd63, 16'hFFFF, 16'hFFFF, 1'b0);
      queue_update(6'd63, 16'd1599, 16'hFFFF, 1'b0);
      queue_update(6'd62, 16'hFFFF, 16'd0, 1'b1);
      queue_update(6'd1, 16'd1601, 16'hAAAA, 1'b0);

      run_phase(12'd0, 12'd2000, 12'd4095, 12'd2100, 1'b1, SNAP_ARRIVE_B, 100, 8, 1'b0);
      run_phase(12'd4095, 12'd4095, 12'd0, 12'd0, 1'b1, SNAP_ARRIVE_A, 60, 8, 1'b0);
      run_phase(12'd0, 12'd0, 12'd4095, 12'd0, 1'b1, SNAP_ARRIVE_A, 120, 8, 1'b1);
      run_phase(12'd4095, 12'd0, 12'd4095, 12'd4095, 1'b1, SNAP_UNUSED, 100, 8, 1'b0);
      run_phase(12'd100, 12'd300, 12'd140, 12'd900, 1'b0, SNAP_ANY, 80, 8, 1'b0);
      for (int k = 0; k < 4; k++)
         run_phase(COORD_W'($urandom_range(4095, 0)), COORD_W'($urandom_range(4095, 0)),
                   COORD_W'($urandom_range(4095, 0)), COORD_W'($urandom_range(4095, 0)),
                   1'b1, snap_mode_type'($urandom_range(3, 0)), 90, (k == 0) ? 64 : 8,
                   1'b0);
      run_phase(12'd2048, 12'd10, 12'd2050, 12'd4000, 1'b1, SNAP_ANY, 100, 16, 1'b0);

      // back-to-back crossings on a fixed steep line
      set_line(12'd100, 12'd0, 12'd100, 12'd4095, 1'b1, SNAP_ANY);
      idle_on = 1'b0;
      for (int g = 0; g < 16; g++) begin
         logic [TRACK_ID_W-1:0] gid;
         gid = TRACK_ID_W'(g % LCC_MAX_TRACKS);
         while (pending_updates.size() > 32) @(posedge clock);
         add_update(make_crossing(gid, SIDE_A));
         add_update(make_crossing(gid, SIDE_B));
         add_update(make_crossing(gid, SIDE_B));
         add_update(make_crossing(gid, SIDE_A));
      end
      run_phase(12'd100, 12'd0, 12'd100, 12'd4095, 1'b1, SNAP_ARRIVE_B, 50, 4, 1'b0);

      drain();
      $display("Run covered %0d track updates and %0d results over %0d line settings.",
               updates_sent, results_checked, settings_run);
      $display("Final totals %0d A to B and %0d B to A, %0d snapshots raised, %0d mismatches.",
               a_to_b_total, b_to_a_total, snaps_seen, mismatch_count);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
